// File: sv/live_object_tracker_top_assert.svh
// Assertion macros for the live object tracker top level.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef LIVE_OBJECT_TRACKER_TOP_ASSERT_SVH
`define LIVE_OBJECT_TRACKER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LOT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lot_pkg.sv
// Shared types and constants of the live object tracker.
// No dependencies; used by lot_regs, lot_ctrl and the top level.
package lot_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_LIVE  = 3'd4,
        ST_TYPE_BAD  = 3'd5,
        ST_SIZE_BAD  = 3'd6,
        ST_IGNORED   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam int          PADDR_W            = 3;
    localparam logic        REG_ENTRIES_IN_USE = 1'b0;
    localparam logic [6:0]  ENTRIES_IN_USE_RST = 7'd64;

    typedef struct packed {
        logic        action;
        logic [63:0] cookie;
        logic [7:0]  obj_type;
        logic [5:0]  obj_size_bits;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  recorded_type;
        logic [5:0]  recorded_size_bits;
        logic        tracking_active;
    } result_t;

    // one table entry as stored in the RAM
    typedef struct packed {
        logic [63:0] cookie;
        logic [7:0]  obj_type;
        logic [5:0]  obj_size_bits;
    } entry_t;

endpackage

// File: sv/lot_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/lot_regs.sv
// APB-style configuration register of the live object tracker.
// Depends on lot_pkg.
module lot_regs
    import lot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [6:0]         entries_in_use
);

    logic [6:0] entries_in_use_reg;
    logic [6:0] entries_in_use_next;
    logic       sel_entries;

    // word index is paddr[2]; byte offset bits are ignored
    assign sel_entries = (paddr[2] == REG_ENTRIES_IN_USE);

    always_comb
    begin
        entries_in_use_next = entries_in_use_reg;
        if (psel && penable && pwrite && sel_entries)
        begin
            entries_in_use_next = pwdata[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= ENTRIES_IN_USE_RST;
        end
        else
        begin
            entries_in_use_reg <= entries_in_use_next;
        end
    end

    assign prdata         = sel_entries ? {25'd0, entries_in_use_reg} : 32'd0;
    assign pready         = 1'b1;
    assign entries_in_use = entries_in_use_reg;

endmodule

// File: sv/lot_ctrl.sv
// Sequencer of the live object tracker: clearing pass, table scan through
// the entry RAM, read-modify-write of one entry and the result register.
// Depends on lot_pkg; drives the ports of one lot_ram instance.
module lot_ctrl
    import lot_pkg::*;
#(
    parameter int ENTRIES = 64,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W = $clog2(ENTRIES + 1),
    localparam int EW    = $bits(entry_t)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    input  logic [6:0]       entries_in_use,
    output logic             done,
    output result_t          result,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output logic [EW-1:0]    mem_wdata,
    output logic [IDX_W-1:0] mem_raddr,
    input  logic [EW-1:0]    mem_rdata
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] n_cfg;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic             pend_last_reg, pend_last_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             match_reg, match_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic [7:0]       rec_type_reg, rec_type_next;
    logic [5:0]       rec_size_reg, rec_size_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             off_reg, off_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;
    entry_t           rd_ent;
    entry_t           new_ent;

    assign rd_ent  = entry_t'(mem_rdata);
    assign new_ent = '{cookie: cmd_reg.cookie, obj_type: cmd_reg.obj_type,
                       obj_size_bits: cmd_reg.obj_size_bits};

    // register values above the table size act as the table size
    assign n_cfg = (32'(entries_in_use) > 32'(ENTRIES)) ? CNT_W'(ENTRIES)
                                                        : CNT_W'(entries_in_use);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        n_next         = n_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        pend_idx_next  = pend_idx_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        rec_type_next  = rec_type_reg;
        rec_size_next  = rec_size_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        off_next       = off_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_reg;
        mem_wdata      = '0;
        mem_raddr      = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    n_next      = n_cfg;
                    rd_idx_next = '0;
                    match_next  = 1'b0;
                    free_next   = 1'b0;
                    if (off_reg || (n_cfg == '0))
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: ST_IGNORED, recorded_type: 8'd0,
                                        recorded_size_bits: 6'd0, tracking_active: 1'b0};
                    end
                    else if (cmd.cookie == 64'd0)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: (cmd.action == ACT_ALLOC) ? ST_NULL
                                                                          : ST_IGNORED,
                                        recorded_type: 8'd0, recorded_size_bits: 6'd0,
                                        tracking_active: 1'b1};
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // compare the entry read in the previous cycle
                if (pend_reg)
                begin
                    if ((rd_ent.cookie == cmd_reg.cookie) && !match_reg)
                    begin
                        match_next     = 1'b1;
                        match_idx_next = pend_idx_reg;
                        rec_type_next  = rd_ent.obj_type;
                        rec_size_next  = rd_ent.obj_size_bits;
                    end
                    else if ((rd_ent.cookie == 64'd0) && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = pend_idx_reg;
                    end
                end
                if (pend_reg && pend_last_reg)
                begin
                    state_next = S_FINISH;
                end
                else if (rd_idx_reg != n_reg)
                begin
                    pend_next      = 1'b1;
                    pend_idx_next  = rd_idx_reg[IDX_W-1:0];
                    pend_last_next = ((rd_idx_reg + CNT_W'(1)) == n_reg);
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                end
            end

            S_FINISH:
            begin
                done_next                      = 1'b1;
                state_next                     = S_IDLE;
                result_next.recorded_type      = match_reg ? rec_type_reg : 8'd0;
                result_next.recorded_size_bits = match_reg ? rec_size_reg : 6'd0;
                if (cmd_reg.action == ACT_ALLOC)
                begin
                    if (match_reg)
                    begin
                        result_next.status = ST_DUPLICATE;
                    end
                    else if (!free_reg)
                    begin
                        result_next.status = ST_FULL;
                        off_next           = 1'b1;
                    end
                    else
                    begin
                        result_next.status = ST_OK;
                        mem_we             = 1'b1;
                        mem_waddr          = free_idx_reg;
                        mem_wdata          = new_ent;
                    end
                end
                else
                begin
                    if (!match_reg)
                    begin
                        result_next.status = ST_NOT_LIVE;
                    end
                    else if (rec_type_reg != cmd_reg.obj_type)
                    begin
                        result_next.status = ST_TYPE_BAD;
                    end
                    else if (rec_size_reg != cmd_reg.obj_size_bits)
                    begin
                        result_next.status = ST_SIZE_BAD;
                    end
                    else
                    begin
                        // free: empty the entry
                        result_next.status = ST_OK;
                        mem_we             = 1'b1;
                        mem_waddr          = match_idx_reg;
                        mem_wdata          = '0;
                    end
                end
                result_next.tracking_active = !off_next;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            off_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            off_reg   <= off_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        n_reg         <= n_next;
        rd_idx_reg    <= rd_idx_next;
        pend_last_reg <= pend_last_next;
        pend_idx_reg  <= pend_idx_next;
        match_reg     <= match_next;
        match_idx_reg <= match_idx_next;
        rec_type_reg  <= rec_type_next;
        rec_size_reg  <= rec_size_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sv/live_object_tracker_top.sv
// Live object tracker: shadow checker for object allocate and free events.
// Channels: command port (start/busy, cmd item), result strobe (done, result
// item), APB-style configuration port with one register, entries_in_use, at
// byte address 0 (reset value 64; values above ENTRIES act as ENTRIES).
// An item is taken at a clock edge with start high and busy low.
// Items that need no table lookup (tracking off, entries_in_use zero, null
// cookie) give their result in the cycle after acceptance; busy stays low.
// All other items scan entries 0 to n-1 of the entry RAM, one read per
// cycle, where n is the effective entries_in_use; busy stays high until
// the result is shown, so no new item is taken while one is scanned.
// The scan rate is set by the single read port of the entry RAM.
// Each result is shown for exactly one cycle with done high and is never
// held back; the receiver cannot stall. The next item may be taken in the
// cycle its predecessor's result is shown.
// After reset the block clears the table, one entry per cycle, with busy
// high; configuration writes are taken during that pass.
// Depends on lot_pkg, lot_regs, lot_ctrl, lot_ram and the assertion header.
`include "live_object_tracker_top_assert.svh"

module live_object_tracker_top
    import lot_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cmd_t               cmd,
    output logic               done,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW    = $bits(entry_t);

    logic [6:0]       entries_in_use;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [EW-1:0]    mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [EW-1:0]    mem_rdata;

    lot_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .entries_in_use (entries_in_use)
    );

    lot_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lot_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .entries_in_use (entries_in_use),
        .done           (done),
        .result         (result),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    // an accepted item either gives its result at once or occupies the block
    `LOT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted item lost")
    // table full always switches tracking off
    `LOT_ASSERT_SAME(a_full_turns_off, done && (result.status == ST_FULL), !result.tracking_active, "full but still active")
    // an ignored item never reports a matched entry
    `LOT_ASSERT_SAME(a_ignored_no_record, done && (result.status == ST_IGNORED), (result.recorded_type == 8'd0) && (result.recorded_size_bits == 6'd0), "ignored item with record")

endmodule
